>>> rtl/sktbs_pkg.sv
package sktbs_pkg;

   // Fixed field widths of the item and result beats.
   localparam int WORD_W     = 64;
   localparam int ENTRY_IN_W = 10;
   localparam int WSEL_IN_W  = 3;
   localparam int MATCH_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // Command codes on the item channel.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PROBE   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_DONE    = 4'b1000
   } search_state_type;

   typedef struct packed {
      logic               found;
      logic [MATCH_W-1:0] match_index;
   } result_type;

endpackage

>>> rtl/sorted_key_table_binary_search_core.sv
// Write and lookup beats without last are taken one per cycle, back to back, while no search runs.
// A lookup beat with last starts a search: each probe forms the middle index and then
// compares the key one word at a time over the single memory read port.
// Synchronous reset clears the control state, entry_count, the search range and the probe
// key; the key table is not cleared and an entry must be written before it is searched.
module sorted_key_table_binary_search_core #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int KEY_WORDS     = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic [sktbs_pkg::ENTRY_IN_W-1:0]        req_entry,
   input  logic [sktbs_pkg::WSEL_IN_W-1:0]         req_word_sel,
   input  logic [sktbs_pkg::WORD_W-1:0]            req_word,
   input  logic                                    req_last,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_found,
   output logic [sktbs_pkg::MATCH_W-1:0]           rsp_match_index,

   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [sktbs_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [sktbs_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [sktbs_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                    pready
);

   // Derived sizes. The range bounds must hold TABLE_ENTRIES itself.
   localparam int DEPTH   = TABLE_ENTRIES * KEY_WORDS;
   localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
   localparam int RANGE_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   // Configuration register. pready is tied high, so an access never has wait states.
   logic [sktbs_pkg::COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic                          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_write && (paddr == sktbs_pkg::REG_ENTRY_COUNT)) begin
         entry_count_in = pwdata[sktbs_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == sktbs_pkg::REG_ENTRY_COUNT) begin
         prdata = sktbs_pkg::CSR_DATA_W'(entry_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Input beat decode. The search controller owns the memory read port
   // and the channel is stalled while it runs, so a table write can never
   // overlap a search read of the same entry.
   logic                         busy;
   logic                         req_accept;
   logic                         entry_ok;
   logic                         sel_ok;
   logic [31:0]                  wr_addr_wide;
   logic [31:0]                  sel_wide;
   logic                         tbl_wr_en;
   logic                         probe_wr_en;
   logic                         search_start;
   logic [RANGE_W-1:0]           search_count;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   assign entry_ok     = 32'(req_entry) < 32'(TABLE_ENTRIES);
   assign sel_ok       = 32'(req_word_sel) < 32'(KEY_WORDS);
   assign sel_wide     = 32'(req_word_sel);
   assign wr_addr_wide = 32'(req_entry) * KEY_WORDS + sel_wide;

   assign tbl_wr_en    = req_accept && (req_cmd == sktbs_pkg::CMD_WRITE) && entry_ok && sel_ok;
   assign probe_wr_en  = req_accept && (req_cmd == sktbs_pkg::CMD_LOOKUP) && sel_ok;
   assign search_start = req_accept && (req_cmd == sktbs_pkg::CMD_LOOKUP) && req_last;

   // A count above the table size searches the whole table.
   assign search_count = (32'(entry_count_ff) > 32'(TABLE_ENTRIES)) ?
                         RANGE_W'(TABLE_ENTRIES) : RANGE_W'(entry_count_ff);

   // Key table memory.
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [sktbs_pkg::WORD_W-1:0] rd_data;

   sktbs_key_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (wr_addr_wide[ADDR_W-1:0]),
      .wr_data (req_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Probe key words, kept across searches.
   logic [IDX_W-1:0]             probe_sel;
   logic [sktbs_pkg::WORD_W-1:0] probe_word;

   sktbs_probe_regs #(
      .KEY_WORDS (KEY_WORDS),
      .IDX_W     (IDX_W)
   ) u_probe_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (probe_wr_en),
      .wr_sel  (sel_wide[IDX_W-1:0]),
      .wr_data (req_word),
      .rd_sel  (probe_sel),
      .rd_data (probe_word)
   );

   // Binary search sequencer.
   logic                  res_valid;
   logic                  res_take;
   sktbs_pkg::result_type res;

   sktbs_search_ctrl #(
      .KEY_WORDS     (KEY_WORDS),
      .ENTRY_W       (ENTRY_W),
      .RANGE_W       (RANGE_W),
      .ADDR_W        (ADDR_W),
      .IDX_W         (IDX_W)
   ) u_search_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (search_start),
      .count      (search_count),
      .probe_word (probe_word),
      .probe_sel  (probe_sel),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .res_valid  (res_valid),
      .res        (res),
      .res_take   (res_take)
   );

   // Output register. The sequencer hands its result over as soon as the
   // register is empty or its beat is being taken, which frees it to accept
   // new input beats while the result waits downstream.
   logic                  rsp_valid_ff, rsp_valid_in;
   sktbs_pkg::result_type rsp_ff, rsp_in;

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_match_index = rsp_ff.match_index;

endmodule

>>> rtl/sktbs_key_mem.sv
module sktbs_key_mem #(
   parameter int DEPTH  = 5120,
   parameter int ADDR_W = 13
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [sktbs_pkg::WORD_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [sktbs_pkg::WORD_W-1:0] rd_data
);

   logic [sktbs_pkg::WORD_W-1:0] mem [DEPTH];
   logic [sktbs_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sktbs_probe_regs.sv
module sktbs_probe_regs #(
   parameter int KEY_WORDS = 5,
   parameter int IDX_W     = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_sel,
   input  logic [sktbs_pkg::WORD_W-1:0] wr_data,
   input  logic [IDX_W-1:0]             rd_sel,
   output logic [sktbs_pkg::WORD_W-1:0] rd_data
);

   logic [sktbs_pkg::WORD_W-1:0] probe_ff [KEY_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            probe_ff[i] <= '0;
         end
      end else if (wr_en) begin
         probe_ff[wr_sel] <= wr_data;
      end
   end

   // The selector only ever holds values below KEY_WORDS.
   assign rd_data = probe_ff[rd_sel];

endmodule

>>> rtl/sktbs_search_ctrl.sv
module sktbs_search_ctrl #(
   parameter int KEY_WORDS     = 5,
   parameter int ENTRY_W       = 10,
   parameter int RANGE_W       = 11,
   parameter int ADDR_W        = 13,
   parameter int IDX_W         = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [RANGE_W-1:0]           count,
   input  logic [sktbs_pkg::WORD_W-1:0] probe_word,
   output logic [IDX_W-1:0]             probe_sel,
   output logic                         rd_en,
   output logic [ADDR_W-1:0]            rd_addr,
   input  logic [sktbs_pkg::WORD_W-1:0] rd_data,
   output logic                         busy,
   output logic                         res_valid,
   output sktbs_pkg::result_type        res,
   input  logic                         res_take
);

   localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(KEY_WORDS - 1);

   sktbs_pkg::search_state_type state_ff, state_in;
   logic [RANGE_W-1:0]    low_ff, low_in;
   logic [RANGE_W-1:0]    high_ff, high_in;
   logic [ENTRY_W-1:0]    mid_ff, mid_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [IDX_W-1:0]      widx_ff, widx_in;
   sktbs_pkg::result_type res_ff, res_in;

   logic [RANGE_W:0]   mid_sum;
   logic [ENTRY_W-1:0] mid_now;
   logic [ADDR_W-1:0]  mid_base;
   logic [31:0]        mid_wide;
   logic               probe_lt;
   logic               probe_gt;

   // Middle of low .. high-1, rounded down; only used while low < high.
   assign mid_sum  = {1'b0, low_ff} + {1'b0, high_ff} - (RANGE_W+1)'(1);
   assign mid_now  = ENTRY_W'(mid_sum[RANGE_W:1]);
   assign mid_base = ADDR_W'(32'(mid_now) * KEY_WORDS);
   assign mid_wide = 32'(mid_ff);

   assign probe_lt = probe_word < rd_data;
   assign probe_gt = probe_word > rd_data;

   always_comb begin
      state_in = state_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      base_in  = base_ff;
      widx_in  = widx_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = ADDR_W'(base_ff + ADDR_W'(widx_ff) + ADDR_W'(1));
      case (state_ff)
         sktbs_pkg::ST_IDLE: begin
            if (start) begin
               low_in   = '0;
               high_in  = count;
               state_in = sktbs_pkg::ST_PROBE;
            end
         end
         sktbs_pkg::ST_PROBE: begin
            if (low_ff < high_ff) begin
               mid_in   = mid_now;
               base_in  = mid_base;
               widx_in  = '0;
               rd_en    = 1'b1;
               rd_addr  = mid_base;
               state_in = sktbs_pkg::ST_COMPARE;
            end else begin
               res_in.found       = 1'b0;
               res_in.match_index = '0;
               state_in           = sktbs_pkg::ST_DONE;
            end
         end
         sktbs_pkg::ST_COMPARE: begin
            // The next word of the same entry is fetched while this one is compared.
            if (probe_lt) begin
               high_in  = RANGE_W'(mid_ff);
               state_in = sktbs_pkg::ST_PROBE;
            end else if (probe_gt) begin
               low_in   = RANGE_W'(mid_ff) + RANGE_W'(1);
               state_in = sktbs_pkg::ST_PROBE;
            end else if (widx_ff == LAST_WORD) begin
               res_in.found       = 1'b1;
               res_in.match_index = mid_wide[sktbs_pkg::MATCH_W-1:0];
               state_in           = sktbs_pkg::ST_DONE;
            end else begin
               rd_en   = 1'b1;
               widx_in = widx_ff + IDX_W'(1);
            end
         end
         sktbs_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = sktbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sktbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sktbs_pkg::ST_IDLE;
         low_ff   <= '0;
         high_ff  <= '0;
      end else begin
         state_ff <= state_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff  <= mid_in;
      base_ff <= base_in;
      widx_ff <= widx_in;
      res_ff  <= res_in;
   end

   assign probe_sel = widx_ff;
   assign busy      = state_ff != sktbs_pkg::ST_IDLE;
   assign res_valid = state_ff == sktbs_pkg::ST_DONE;
   assign res       = res_ff;

endmodule
